// ----- rtl/stlc_pkg.sv -----
// ----------------------------------------------------------------------------
// stlc_pkg
// Types and fixed constants shared by the tag lookup block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stlc_pkg;

    localparam int ADDR_W      = 32;
    localparam int TAG_W       = 32;
    localparam int RAW_SET_W   = 8;
    localparam int WAYS_EXT_W  = 5;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = 2;

    localparam logic [4:0] OFFSET_LIMIT = 5'd16;
    localparam logic [3:0] INDEX_LIMIT  = 4'd8;

    localparam logic [4:0] OFFSET_RESET = 5'd5;
    localparam logic [3:0] INDEX_RESET  = 4'd6;
    localparam logic [3:0] WAYS_RESET   = 4'd4;

    localparam logic [REG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WAYS        = 2'd2;

    typedef struct packed {
        logic [4:0] offset_bits;
        logic [3:0] index_bits;
        logic [3:0] ways;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } red_stat_t;

endpackage

// ----- rtl/stlc_req_if.sv -----
// ----------------------------------------------------------------------------
// stlc_req_if
// Access request channel: byte address and load or store flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stlc_req_if;
    logic                       valid;
    logic                       ready;
    logic [stlc_pkg::ADDR_W-1:0] address;
    logic                       is_store;

    modport source (output valid, output address, output is_store, input ready);
    modport sink   (input valid, input address, input is_store, output ready);
endinterface

// ----- rtl/stlc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// stlc_rsp_if
// Lookup result channel: hit and dirty eviction flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stlc_rsp_if;
    logic valid;
    logic ready;
    logic hit;
    logic dirty_evict;

    modport source (output valid, output hit, output dirty_evict, input ready);
    modport sink   (input valid, input hit, input dirty_evict, output ready);
endinterface

// ----- rtl/stlc_apb_regs.sv -----
// ----------------------------------------------------------------------------
// stlc_apb_regs
// APB-style configuration registers: offset bits, index bits and ways.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stlc_apb_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stlc_pkg::PADDR_W-1:0] paddr,
    input  logic [stlc_pkg::PDATA_W-1:0] pwdata,
    output logic [stlc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output stlc_pkg::cfg_t               cfg
);

    stlc_pkg::cfg_t                  cfg_reg;
    stlc_pkg::cfg_t                  cfg_next;
    logic [stlc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                            wr_en;

    assign reg_idx = paddr[stlc_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                stlc_pkg::REG_OFFSET_BITS: cfg_next.offset_bits = pwdata[4:0];
                stlc_pkg::REG_INDEX_BITS:  cfg_next.index_bits  = pwdata[3:0];
                stlc_pkg::REG_WAYS:        cfg_next.ways        = pwdata[3:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            stlc_pkg::REG_OFFSET_BITS: prdata = {27'd0, cfg_reg.offset_bits};
            stlc_pkg::REG_INDEX_BITS:  prdata = {28'd0, cfg_reg.index_bits};
            stlc_pkg::REG_WAYS:        prdata = {28'd0, cfg_reg.ways};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_bits <= stlc_pkg::OFFSET_RESET;
            cfg_reg.index_bits  <= stlc_pkg::INDEX_RESET;
            cfg_reg.ways        <= stlc_pkg::WAYS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/stlc_ram.sv -----
// ----------------------------------------------------------------------------
// stlc_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stlc_ram
#(
    parameter int DW = 33,
    parameter int AW = 11
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

// ----- rtl/stlc_set_reduce.sv -----
// ----------------------------------------------------------------------------
// stlc_set_reduce
// Reduces the raw set field modulo the number of physical sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stlc_set_reduce
#(
    parameter int MAX_SETS = 256,
    parameter int SET_W    = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [stlc_pkg::RAW_SET_W-1:0] raw_set,
    output stlc_pkg::red_stat_t            stat,
    output logic [SET_W-1:0]               set_idx
);

    localparam int RAW_W = stlc_pkg::RAW_SET_W;

    logic [RAW_W-1:0] rem_reg;
    logic [RAW_W-1:0] rem_next;
    logic             done_reg;

    assign set_idx   = SET_W'(rem_reg);
    assign stat.done = done_reg;

    generate
        if (MAX_SETS < (2 ** RAW_W))
        begin : g_recip
            localparam int RECIP_SH = 2 * RAW_W;
            localparam int RECIP_W  = RECIP_SH + 1;
            localparam int PROD_W   = RAW_W + RECIP_W;
            localparam int BACK_W   = 2 * RAW_W;
            localparam logic [RECIP_W-1:0] RECIP =
                RECIP_W'(((2 ** RECIP_SH) + MAX_SETS - 1) / MAX_SETS);

            logic [RAW_W-1:0] quot_reg;
            logic [RAW_W-1:0] quot_next;
            logic [RAW_W-1:0] quot_calc;
            logic [RAW_W-1:0] back;
            logic             busy_reg;

            // quotient by reciprocal multiplication, exact over every raw set value
            assign quot_calc = RAW_W'((PROD_W'(raw_set) * PROD_W'(RECIP)) >> RECIP_SH);
            assign back      = RAW_W'(BACK_W'(quot_reg) * BACK_W'(MAX_SETS));
            assign stat.busy = busy_reg;

            always_comb
            begin
                rem_next  = rem_reg;
                quot_next = quot_reg;
                if (start)
                begin
                    rem_next  = raw_set;
                    quot_next = quot_calc;
                end
                else if (busy_reg)
                begin
                    rem_next = rem_reg - back;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                end
                else
                begin
                    busy_reg <= start;
                    done_reg <= busy_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                quot_reg <= quot_next;
            end
        end
        else
        begin : g_pass
            // every raw set value already names a physical set
            assign stat.busy = 1'b0;

            always_comb
            begin
                rem_next = start ? raw_set : rem_reg;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

endmodule

// ----- rtl/set_assoc_cache_tag_lookup_core.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_core
// Tag and dirty store of a write-back set-associative cache. Each request
// splits its address by the configured offset and index widths, scans the
// ways of the set one per cycle through a single tag comparator, reports a
// hit on the lowest matching way or replaces the way named by the set's
// victim pointer, and returns hit and dirty-eviction flags. One request is
// in flight at a time: after a request is taken ready stays low through the
// set reduction (a reciprocal step when MAX_SETS is below 256, a plain
// pass otherwise), the way scan with one tag memory read a cycle, and any
// wait for the result register to be taken. After reset a clearing pass
// zeroes the tag, dirty and pointer memories over all 2**(SET_W + WAY_W)
// tag entries with ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module set_assoc_cache_tag_lookup_core
#(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    stlc_req_if.sink                     req,
    stlc_rsp_if.source                   rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stlc_pkg::PADDR_W-1:0] paddr,
    input  logic [stlc_pkg::PDATA_W-1:0] pwdata,
    output logic [stlc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W   = $clog2(MAX_WAYS + 1);
    localparam int AW      = SET_W + WAY_W;
    localparam int TAG_W   = stlc_pkg::TAG_W;
    localparam int ENTRY_W = TAG_W + 1;
    localparam int WX_W    = stlc_pkg::WAYS_EXT_W;
    localparam int RAW_W   = stlc_pkg::RAW_SET_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SETUP = 5'b00100,
        S_SCAN  = 5'b01000,
        S_WRITE = 5'b10000
    } state_t;

    stlc_pkg::cfg_t      cfg;
    stlc_pkg::red_stat_t red_stat;
    logic [SET_W-1:0]    red_set;
    logic                red_start;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic              out_vld_reg, out_vld_next;

    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic              store_reg, store_next;
    logic [SET_W-1:0]  set_reg, set_next;
    logic [WAY_W-1:0]  cmp_way_reg, cmp_way_next;
    logic              hit_reg, hit_next;
    logic [WAY_W-1:0]  way_reg, way_next;
    logic              vdirty_reg, vdirty_next;
    logic              out_hit_reg, out_hit_next;
    logic              out_dirty_reg, out_dirty_next;

    logic [4:0]        off_eff;
    logic [3:0]        idx_eff;
    logic [4:0]        tag_shift;
    logic [WX_W-1:0]   ways_ext;
    logic [WX_W-1:0]   nways_ext;
    logic [CNT_W-1:0]  nways;
    logic [TAG_W-1:0]  tag_calc;
    logic [RAW_W-1:0]  raw_set;
    logic [WAY_W-1:0]  victim;
    logic [CNT_W-1:0]  way_plus;
    logic [WAY_W-1:0]  ptr_new;
    logic              cmp_last;
    logic              issuing;

    logic               tm_we, tm_re;
    logic [AW-1:0]      tm_waddr, tm_raddr;
    logic [ENTRY_W-1:0] tm_wdata, tm_rdata;
    logic               pm_we, pm_re;
    logic [SET_W-1:0]   pm_waddr, pm_raddr;
    logic [WAY_W-1:0]   pm_wdata, pm_rdata;

    stlc_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stlc_set_reduce #(.MAX_SETS(MAX_SETS), .SET_W(SET_W)) u_reduce
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (red_start),
        .raw_set (raw_set),
        .stat    (red_stat),
        .set_idx (red_set)
    );

    // tag in the upper bits, dirty mark in bit 0
    stlc_ram #(.DW(ENTRY_W), .AW(AW)) u_tag_ram
    (
        .clk   (clk),
        .we    (tm_we),
        .waddr (tm_waddr),
        .wdata (tm_wdata),
        .re    (tm_re),
        .raddr (tm_raddr),
        .rdata (tm_rdata)
    );

    stlc_ram #(.DW(WAY_W), .AW(SET_W)) u_ptr_ram
    (
        .clk   (clk),
        .we    (pm_we),
        .waddr (pm_waddr),
        .wdata (pm_wdata),
        .re    (pm_re),
        .raddr (pm_raddr),
        .rdata (pm_rdata)
    );

    // effective configuration
    assign off_eff   = (cfg.offset_bits > stlc_pkg::OFFSET_LIMIT) ?
                       stlc_pkg::OFFSET_LIMIT : cfg.offset_bits;
    assign idx_eff   = (cfg.index_bits > stlc_pkg::INDEX_LIMIT) ?
                       stlc_pkg::INDEX_LIMIT : cfg.index_bits;
    assign tag_shift = off_eff + {1'b0, idx_eff};
    assign ways_ext  = {1'b0, cfg.ways};
    assign nways_ext = (cfg.ways == 4'd0)            ? WX_W'(1) :
                       (ways_ext > WX_W'(MAX_WAYS))  ? WX_W'(MAX_WAYS) : ways_ext;
    assign nways     = CNT_W'(nways_ext);

    assign tag_calc  = req.address >> tag_shift;
    assign raw_set   = RAW_W'(req.address >> off_eff) & ~({RAW_W{1'b1}} << idx_eff);

    // a pointer left beyond a lowered way count falls back to way 0
    assign victim    = (CNT_W'(pm_rdata) >= nways) ? '0 : pm_rdata;
    assign way_plus  = CNT_W'(way_reg) + CNT_W'(1);
    assign ptr_new   = (way_plus < nways) ? WAY_W'(way_plus) : '0;
    assign cmp_last  = (CNT_W'(cmp_way_reg) == CNT_W'(nways - CNT_W'(1)));
    assign issuing   = (issue_reg < nways);

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_vld_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.dirty_evict = out_dirty_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        issue_next     = issue_reg;
        cmp_vld_next   = 1'b0;
        out_vld_next   = out_vld_reg;
        tag_next       = tag_reg;
        store_next     = store_reg;
        set_next       = set_reg;
        cmp_way_next   = cmp_way_reg;
        hit_next       = hit_reg;
        way_next       = way_reg;
        vdirty_next    = vdirty_reg;
        out_hit_next   = out_hit_reg;
        out_dirty_next = out_dirty_reg;
        red_start      = 1'b0;
        tm_we          = 1'b0;
        tm_waddr       = {set_reg, way_reg};
        tm_wdata       = {tag_reg, store_reg};
        tm_re          = 1'b0;
        tm_raddr       = {set_reg, issue_reg[WAY_W-1:0]};
        pm_we          = 1'b0;
        pm_waddr       = set_reg;
        pm_wdata       = ptr_new;
        pm_re          = 1'b0;
        pm_raddr       = set_reg;

        if (out_vld_reg && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                tm_we    = 1'b1;
                tm_waddr = clr_reg;
                tm_wdata = '0;
                pm_we    = 1'b1;
                pm_waddr = clr_reg[AW-1:WAY_W];
                pm_wdata = '0;
                clr_next = AW'(clr_reg + 1'b1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    tag_next   = tag_calc;
                    store_next = req.is_store;
                    red_start  = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (red_stat.done)
                begin
                    set_next   = red_set;
                    issue_next = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // read of way n overlaps the compare of way n-1
                if (issuing)
                begin
                    tm_re      = 1'b1;
                    pm_re      = (issue_reg == '0);
                    issue_next = CNT_W'(issue_reg + 1'b1);
                end
                cmp_vld_next = issuing;
                cmp_way_next = issue_reg[WAY_W-1:0];
                if (cmp_vld_reg)
                begin
                    if (cmp_way_reg == victim)
                    begin
                        vdirty_next = tm_rdata[0];
                    end
                    if (tm_rdata[ENTRY_W-1:1] == tag_reg)
                    begin
                        hit_next   = 1'b1;
                        way_next   = cmp_way_reg;
                        state_next = S_WRITE;
                    end
                    else if (cmp_last)
                    begin
                        hit_next   = 1'b0;
                        way_next   = victim;
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    // a load hit leaves the entry as it is
                    tm_we          = !hit_reg || store_reg;
                    pm_we          = (nways != CNT_W'(1));
                    out_vld_next   = 1'b1;
                    out_hit_next   = hit_reg;
                    out_dirty_next = !hit_reg && vdirty_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            issue_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            issue_reg   <= issue_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg       <= tag_next;
        store_reg     <= store_next;
        set_reg       <= set_next;
        cmp_way_reg   <= cmp_way_next;
        hit_reg       <= hit_next;
        way_reg       <= way_next;
        vdirty_reg    <= vdirty_next;
        out_hit_reg   <= out_hit_next;
        out_dirty_reg <= out_dirty_next;
    end

    a_hit_not_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> !rsp.dirty_evict)
        else $error("hit reported with dirty eviction");

    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_SETUP))
        else $error("accepted request did not start set reduction");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_reg <= nways))
        else $error("way scan ran past the ways in use");

    a_reduce_busy: assert property (@(posedge clk) disable iff (!rst_n)
        red_stat.busy |-> (state_reg == S_SETUP))
        else $error("set reduction busy outside setup");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && rsp.valid && !rsp.ready) |=>
        (rsp.valid && $stable(rsp.hit) && $stable(rsp.dirty_evict)))
        else $error("pending result overwritten");

endmodule
